@@ rtl/core/u8l1_pkg.sv @@
// ----------------------------------------------------------------------------
// u8l1_pkg
// shared types, constants and the fold table of the utf-8 to latin-1 converter
// ----------------------------------------------------------------------------
package u8l1_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 16;
  localparam int CP_W   = 21;

  localparam logic [BYTE_W-1:0] QMARK = 8'h3F;

  typedef struct packed {
    logic load;
    logic latch;
    logic put;
    logic shift;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic dec_hold;
    logic emit_done;
    logic put_stall;
    logic fin_stall;
  } sts_t;

  typedef struct packed {
    logic [1:0]        len;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
  } fold_t;

  function automatic fold_t fold_lookup(input logic [CP_W-1:0] cp);
    fold_t f;
    f = '{len: 2'd1, b0: QMARK, b1: 8'h00, b2: 8'h00};
    case (cp) inside
      21'h2018, 21'h2019, 21'h201A, 21'h201B: f.b0 = 8'h27;
      21'h201C, 21'h201D, 21'h201E, 21'h201F: f.b0 = 8'h22;
      21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014, 21'h2015: f.b0 = 8'h2D;
      21'h2022: f.b0 = 8'h2A;
      21'h2026: f = '{len: 2'd3, b0: 8'h2E, b1: 8'h2E, b2: 8'h2E};
      21'h202F, 21'h2009: f.b0 = 8'h20;
      21'h20AC: f = '{len: 2'd3, b0: 8'h45, b1: 8'h55, b2: 8'h52};
      21'h2103: f = '{len: 2'd2, b0: 8'hB0, b1: 8'h43, b2: 8'h00};
      21'h2109: f = '{len: 2'd2, b0: 8'hB0, b1: 8'h46, b2: 8'h00};
      21'h00B5, 21'h03BC: f.b0 = 8'hB5;
      default: f.b0 = QMARK;
    endcase
    return f;
  endfunction

endpackage

@@ rtl/core/utf8_to_latin1_folding_converter_core.sv @@
// ----------------------------------------------------------------------------
// utf8_to_latin1_folding_converter_core
// utf-8 byte stream to latin-1 with folding of common typographic code points
// ----------------------------------------------------------------------------
//  channel  direction  signals                  contents
//  s        in         tvalid tready tdata tlast tdata[7:0] in_byte, tlast in_last
//  m        out        tvalid tready tdata tuser tlast
//                                               tdata[7:0] out_byte,
//                                               tdata[23:8] string_length,
//                                               tuser[0] out_valid,
//                                               tuser[1] run_last, tlast string_end
//  cfg      in         valid ready data         data[15:0] out_capacity
//
//  one request at a time: accept, then per decoded sequence a decode step,
//  an emit step per emitted byte and a shift step, then a final decode
//  and a close step
//  a full output register stalls the emit and close cycles
//  reset empties the byte buffer, clears the count and sets capacity to 65535
// ----------------------------------------------------------------------------
module utf8_to_latin1_folding_converter_core import u8l1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] string_length
  output logic [1:0]  m_tuser,   // [0] out_valid, [1] run_last
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  cmd_t              cmd;
  sts_t              sts;
  logic [BYTE_W-1:0] out_byte;
  logic              out_flag;
  logic              out_run_last;
  logic [CNT_W-1:0]  out_str_len;

  assign cfg_ready = !rst;

  u8l1_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  u8l1_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_byte      (s_tdata),
    .in_last      (s_tlast),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .out_take     (m_tready),
    .out_vld      (m_tvalid),
    .out_byte     (out_byte),
    .out_flag     (out_flag),
    .out_run_last (out_run_last),
    .out_str_end  (m_tlast),
    .out_str_len  (out_str_len)
  );

  assign m_tdata = {out_str_len, out_byte};
  assign m_tuser = {out_run_last, out_flag};

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted again while a request is in work");

  a_marker_closes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tuser[1] && m_tdata[7:0] == 8'h00))
    else $error("end-only result does not close the string");

  a_length_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[23:8] == 16'h0000))
    else $error("string length given before the end of the string");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser[1])
    else $error("string end not on the last result of its request");
`endif

endmodule

@@ rtl/core/u8l1_ctrl.sv @@
// ----------------------------------------------------------------------------
// u8l1_ctrl
// sequencer: take a byte, decode held sequences, emit bytes, close the request
// ----------------------------------------------------------------------------
module u8l1_ctrl import u8l1_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEC  = 2'd1;
  localparam logic [1:0] ST_PUT  = 2'd2;
  localparam logic [1:0] ST_END  = 2'd3;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        if (sts.dec_hold) begin
          state_next = ST_END;
        end else begin
          cmd.latch  = 1'b1;
          state_next = ST_PUT;
        end
      end
      ST_PUT: begin
        if (sts.emit_done) begin
          cmd.shift  = 1'b1;
          state_next = ST_DEC;
        end else if (!sts.put_stall) begin
          cmd.put = 1'b1;
        end
      end
      ST_END: begin
        if (!sts.fin_stall) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign s_tready = (state == ST_IDLE) && !rst;

endmodule

@@ rtl/core/u8l1_datapath.sv @@
// ----------------------------------------------------------------------------
// u8l1_datapath
// byte buffer, sequence decoder, fold lookup, byte counter and output register
// ----------------------------------------------------------------------------
module u8l1_datapath import u8l1_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              out_take,
  output logic              out_vld,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_flag,
  output logic              out_run_last,
  output logic              out_str_end,
  output logic [CNT_W-1:0]  out_str_len
);

  logic [BYTE_W-1:0] buffer [4];
  logic [2:0]        fill;
  logic              last_r;
  logic [CNT_W-1:0]  capacity;
  logic [CNT_W-1:0]  written;

  logic [BYTE_W-1:0] ebyte [3];
  logic [1:0]        ecnt;
  logic [1:0]        eidx;
  logic [2:0]        eused;

  logic              hold_vld;
  logic [BYTE_W-1:0] hold_byte;

  logic              lead_ok, cont_ok, overlong, short_seq, dec_good, dec_wait;
  logic [1:0]        extra;
  logic [2:0]        need;
  logic [CP_W-1:0]   cp;
  fold_t             fold;
  fold_t             elist;
  logic              allow, out_free;

  // decoder
  always_comb begin
    lead_ok = 1'b1;
    extra   = 2'd0;
    cp      = '0;
    if (!buffer[0][7]) begin
      cp = {13'd0, buffer[0]};
    end else if (buffer[0][7:5] == 3'b110) begin
      extra = 2'd1;
      cp    = {10'd0, buffer[0][4:0], buffer[1][5:0]};
    end else if (buffer[0][7:4] == 4'b1110) begin
      extra = 2'd2;
      cp    = {5'd0, buffer[0][3:0], buffer[1][5:0], buffer[2][5:0]};
    end else if (buffer[0][7:3] == 5'b11110) begin
      extra = 2'd3;
      cp    = {buffer[0][2:0], buffer[1][5:0], buffer[2][5:0], buffer[3][5:0]};
    end else begin
      lead_ok = 1'b0;
    end
    need      = {1'b0, extra} + 3'd1;
    short_seq = fill < need;
    cont_ok   = (extra < 2'd1 || buffer[1][7:6] == 2'b10) &&
                (extra < 2'd2 || buffer[2][7:6] == 2'b10) &&
                (extra < 2'd3 || buffer[3][7:6] == 2'b10);
    overlong  = (extra == 2'd1 && cp < 21'h80) ||
                (extra == 2'd2 && cp < 21'h800) ||
                (extra == 2'd3 && cp < 21'h10000);
    dec_wait  = lead_ok && short_seq && !last_r;
    dec_good  = lead_ok && !short_seq && cont_ok && !overlong;
  end

  // bytes to emit for the decoded sequence, or the lead byte as is when it does not decode
  always_comb begin
    fold = fold_lookup(cp);
    if (dec_good && cp < 21'h100) begin
      elist = '{len: 2'd1, b0: cp[BYTE_W-1:0], b1: 8'h00, b2: 8'h00};
    end else if (dec_good) begin
      elist = fold;
    end else begin
      elist = '{len: 2'd1, b0: buffer[0], b1: 8'h00, b2: 8'h00};
    end
  end

  assign out_free = !out_vld || out_take;
  assign allow    = (({1'b0, written} + 17'd1) < {1'b0, capacity}) && (written != '1);

  assign sts.dec_hold  = (fill == 3'd0) || dec_wait;
  assign sts.emit_done = (eidx == ecnt);
  assign sts.put_stall = allow && hold_vld && !out_free;
  assign sts.fin_stall = (hold_vld || last_r) && !out_free;

  // buffer and decode bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 3'd0;
    end else if (cmd.load) begin
      buffer[fill[1:0]] <= in_byte;
      fill              <= fill + 3'd1;
      last_r            <= in_last;
    end else if (cmd.shift) begin
      case (eused)
        3'd1: begin
          buffer[0] <= buffer[1];
          buffer[1] <= buffer[2];
          buffer[2] <= buffer[3];
        end
        3'd2: begin
          buffer[0] <= buffer[2];
          buffer[1] <= buffer[3];
        end
        3'd3: buffer[0] <= buffer[3];
        default: ;
      endcase
      fill <= fill - eused;
    end else if (cmd.finish && last_r) begin
      fill <= 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ebyte[0] <= elist.b0;
      ebyte[1] <= elist.b1;
      ebyte[2] <= elist.b2;
      ecnt     <= elist.len;
      eused    <= dec_good ? need : 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eidx <= 2'd0;
    end else if (cmd.latch) begin
      eidx <= 2'd0;
    end else if (cmd.put) begin
      eidx <= eidx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '1;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // byte counter and held result
  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      hold_vld <= 1'b0;
    end else if (cmd.put && allow) begin
      written   <= written + CNT_W'(1);
      hold_vld  <= 1'b1;
      hold_byte <= ebyte[eidx];
    end else if (cmd.finish) begin
      hold_vld <= 1'b0;
      if (last_r) begin
        written <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (cmd.put && allow && hold_vld) begin
      out_vld      <= 1'b1;
      out_byte     <= hold_byte;
      out_flag     <= 1'b1;
      out_run_last <= 1'b0;
      out_str_end  <= 1'b0;
      out_str_len  <= '0;
    end else if (cmd.finish && (hold_vld || last_r)) begin
      out_vld      <= 1'b1;
      out_byte     <= hold_vld ? hold_byte : 8'h00;
      out_flag     <= hold_vld;
      out_run_last <= 1'b1;
      out_str_end  <= last_r;
      out_str_len  <= last_r ? written : '0;
    end else if (out_take) begin
      out_vld <= 1'b0;
    end
  end

endmodule
